/* sv/cc20_pkg.sv */
// Shared types, constants and a helper function for the ChaCha20 stream cipher.
`default_nettype none

package cc20_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	// ChaCha "expand 32-byte k" words
	localparam logic [WordW-1:0] SIGMA_0 = 32'h61707865;
	localparam logic [WordW-1:0] SIGMA_1 = 32'h3320646e;
	localparam logic [WordW-1:0] SIGMA_2 = 32'h79622d32;
	localparam logic [WordW-1:0] SIGMA_3 = 32'h6b206574;

	// rotate amounts of the two quarter-round halves
	localparam int unsigned ROT_A0 = 16;
	localparam int unsigned ROT_B0 = 12;
	localparam int unsigned ROT_A1 = 8;
	localparam int unsigned ROT_B1 = 7;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_KEY_01   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_KEY_23   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_KEY_45   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_KEY_67   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_NONCE_01 = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_NONCE_2  = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_INIT_CTR = 3'd6;

	localparam logic [WordW-1:0] INIT_CTR_RESET = 32'd1;

	typedef struct packed {
		logic [31:0] plain_word;
		logic [2:0]  valid_bytes;
		logic        last_word;
	} plain_item_t;

	typedef struct packed {
		logic [31:0] cipher_word;
		logic [2:0]  out_valid_bytes;
		logic        out_last;
	} cipher_item_t;

	typedef struct packed {
		logic [7:0][WordW-1:0] key;
		logic [2:0][WordW-1:0] nonce;
		logic [WordW-1:0]      init_ctr;
	} cfg_t;

	typedef struct packed {
		logic accept;  // take the input item
		logic load;    // load initial block state
		logic round;   // one quarter-round half on all four lanes
		logic phase;   // 0: first half (16/12), 1: second half (8/7)
		logic diag;    // diagonal round
		logic feed;    // feed-forward add
		logic emit;    // produce the output item
	} cc20_cmd_t;

	typedef struct packed {
		logic need_block;
		logic out_free;
	} cc20_sts_t;

	function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] x,
			input int unsigned r);
		return (x << r) | (x >> (WordW - r));
	endfunction

endpackage

`default_nettype wire

/* sv/chacha20_stream_cipher.sv */
// An accepted item is XORed with the keystream word at hand, or, when a new 64-byte block is
// needed, after the block is loaded, run through DOUBLE_ROUNDS double rounds and fed forward.
// The input is stalled until the result is taken into the output register, so one item is in
// flight at a time; a single round unit does one quarter-round half on all four lanes per step.
// Reset (arst_n low) clears the controller, position and message flag, keys and nonce,
// and loads the initial counter with 1; the keystream state is not cleared.
`default_nettype none

module chacha20_stream_cipher
	import cc20_pkg::*;
#(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                plain_valid,
	output logic                     plain_stall,
	input  wire plain_item_t         plain_item,
	output logic                     cipher_valid,
	input  wire logic                cipher_stall,
	output cipher_item_t             cipher_item,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata
);

	cfg_t      cfg;
	cc20_cmd_t cmd;
	cc20_sts_t sts;

	cc20_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cc20_ctrl #(
		.DOUBLE_ROUNDS (DOUBLE_ROUNDS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.plain_valid (plain_valid),
		.plain_stall (plain_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	cc20_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.plain_item   (plain_item),
		.cipher_stall (cipher_stall),
		.cipher_valid (cipher_valid),
		.cipher_item  (cipher_item)
	);

endmodule

`default_nettype wire

/* sv/cc20_cfg_regs.sv */
// Configuration register file: key, nonce and initial block counter.
`default_nettype none

module cc20_cfg_regs
	import cc20_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                     cfg
);

	logic [CfgDataW-1:0] key01_q, key23_q, key45_q, key67_q, nonce01_q;
	logic [WordW-1:0]    nonce2_q, init_ctr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q    <= '0;
			key23_q    <= '0;
			key45_q    <= '0;
			key67_q    <= '0;
			nonce01_q  <= '0;
			nonce2_q   <= '0;
			init_ctr_q <= INIT_CTR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_01:   key01_q    <= cfg_wdata;
				CFG_KEY_23:   key23_q    <= cfg_wdata;
				CFG_KEY_45:   key45_q    <= cfg_wdata;
				CFG_KEY_67:   key67_q    <= cfg_wdata;
				CFG_NONCE_01: nonce01_q  <= cfg_wdata;
				CFG_NONCE_2:  nonce2_q   <= cfg_wdata[WordW-1:0];
				CFG_INIT_CTR: init_ctr_q <= cfg_wdata[WordW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.key[0]   = key01_q[31:0];
		cfg.key[1]   = key01_q[63:32];
		cfg.key[2]   = key23_q[31:0];
		cfg.key[3]   = key23_q[63:32];
		cfg.key[4]   = key45_q[31:0];
		cfg.key[5]   = key45_q[63:32];
		cfg.key[6]   = key67_q[31:0];
		cfg.key[7]   = key67_q[63:32];
		cfg.nonce[0] = nonce01_q[31:0];
		cfg.nonce[1] = nonce01_q[63:32];
		cfg.nonce[2] = nonce2_q;
		cfg.init_ctr = init_ctr_q;
	end

endmodule

`default_nettype wire

/* sv/cc20_ctrl.sv */
// Controller state machine: sequences block computation and word output.
`default_nettype none

module cc20_ctrl
	import cc20_pkg::*;
#(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      plain_valid,
	output logic           plain_stall,
	input  wire cc20_sts_t sts,
	output cc20_cmd_t      cmd
);

	localparam int unsigned Steps = 4 * DOUBLE_ROUNDS;
	localparam int unsigned StepW = $clog2(Steps);
	localparam logic [StepW-1:0] LastStep = StepW'(Steps - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FEED  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [StepW-1:0] step_q;

	assign plain_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		// step bit 0 picks the quarter-round half, bit 1 column or diagonal
		cmd.phase = step_q[0];
		cmd.diag = step_q[1];
		unique case (state_q)
			ST_IDLE: begin
				if (plain_valid) begin
					cmd.accept = 1'b1;
					state_d = sts.need_block ? ST_LOAD : ST_EMIT;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (step_q == LastStep)
					state_d = ST_FEED;
			end
			ST_FEED: begin
				cmd.feed = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				step_q <= '0;
			else if (cmd.round)
				step_q <= step_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* sv/cc20_datapath.sv */
// Datapath: block state, quarter-round unit, feed-forward, word XOR and output register.
`default_nettype none

module cc20_datapath
	import cc20_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire cc20_cmd_t   cmd,
	output cc20_sts_t        sts,
	input  wire plain_item_t plain_item,
	input  wire logic        cipher_stall,
	output logic             cipher_valid,
	output cipher_item_t     cipher_item
);

	logic [WordW-1:0] st_q [16];
	logic [WordW-1:0] init_w [16];
	logic [WordW-1:0] round_w [16];
	plain_item_t      item_q;
	cipher_item_t     out_q;
	logic             out_valid_q;
	logic [3:0]       pos_q;
	logic [WordW-1:0] ctr_q;
	logic             in_msg_q;
	logic [3:0]       pos_inc;
	logic [WordW-1:0] ks_word;
	logic [31:0]      keep;

	assign sts.need_block = !in_msg_q || (pos_q == 4'd0);
	assign sts.out_free = !out_valid_q || !cipher_stall;
	assign cipher_valid = out_valid_q;
	assign cipher_item = out_q;

	always_comb begin
		init_w[0] = SIGMA_0;
		init_w[1] = SIGMA_1;
		init_w[2] = SIGMA_2;
		init_w[3] = SIGMA_3;
		for (int k = 0; k < 8; k++)
			init_w[4+k] = cfg.key[k];
		init_w[12] = ctr_q;
		init_w[13] = cfg.nonce[0];
		init_w[14] = cfg.nonce[1];
		init_w[15] = cfg.nonce[2];
	end

	// half a quarter round on four independent lanes; diagonal rounds
	// rotate the b, c and d rows by one, two and three lanes
	always_comb begin
		logic [1:0]       bi, ci, di;
		logic [WordW-1:0] a, b, c, d, a2, b2, c2, d2;
		round_w = st_q;
		for (int i = 0; i < 4; i++) begin
			bi = 2'(i + (cmd.diag ? 1 : 0));
			ci = 2'(i + (cmd.diag ? 2 : 0));
			di = 2'(i + (cmd.diag ? 3 : 0));
			a = st_q[i];
			b = st_q[4 + bi];
			c = st_q[8 + ci];
			d = st_q[12 + di];
			a2 = a + b;
			d2 = cmd.phase ? rotl32(d ^ a2, ROT_A1) : rotl32(d ^ a2, ROT_A0);
			c2 = c + d2;
			b2 = cmd.phase ? rotl32(b ^ c2, ROT_B1) : rotl32(b ^ c2, ROT_B0);
			round_w[i] = a2;
			round_w[4 + bi] = b2;
			round_w[8 + ci] = c2;
			round_w[12 + di] = d2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			st_q <= init_w;
		else if (cmd.round)
			st_q <= round_w;
		else if (cmd.feed) begin
			for (int k = 0; k < 16; k++)
				st_q[k] <= st_q[k] + init_w[k];
		end
	end

	assign ks_word = st_q[pos_q];
	assign pos_inc = pos_q + 4'd1;

	always_comb begin
		for (int k = 0; k < 4; k++)
			keep[8*k +: 8] = (item_q.valid_bytes > 3'(k)) ? 8'hFF : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			item_q <= plain_item;
		if (cmd.emit) begin
			out_q.cipher_word     <= (item_q.plain_word ^ ks_word) & keep;
			out_q.out_valid_bytes <= item_q.valid_bytes;
			out_q.out_last        <= item_q.last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			ctr_q       <= INIT_CTR_RESET;
			in_msg_q    <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!cipher_stall)
				out_valid_q <= 1'b0;

			// message start: restart counter and word position
			if (cmd.accept && !in_msg_q) begin
				ctr_q <= cfg.init_ctr;
				pos_q <= '0;
			end else if (cmd.emit) begin
				if (item_q.last_word) begin
					in_msg_q <= 1'b0;
					pos_q    <= '0;
					ctr_q    <= cfg.init_ctr;
				end else begin
					in_msg_q <= 1'b1;
					pos_q    <= pos_inc;
					if (pos_inc == 4'd0)
						ctr_q <= ctr_q + 32'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sv/cc20_checker.sv */
// Port-level checker for the ChaCha20 stream cipher, bound to the top level.
`default_nettype none

module cc20_checker
	import cc20_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         plain_valid,
	input wire logic         plain_stall,
	input wire plain_item_t  plain_item,
	input wire logic         cipher_valid,
	input wire logic         cipher_stall,
	input wire cipher_item_t cipher_item
);

	// one item in flight: input closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(plain_valid && !plain_stall) |=> plain_stall)
		else $error("input open right after accepting an item");

	// a new result only appears while an item is held
	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cipher_valid) |-> $past(plain_stall))
		else $error("result without an item in flight");

	// bytes past the valid count are zero
	a_invalid_bytes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid |->
			(cipher_item.out_valid_bytes == 3'd0 && cipher_item.cipher_word == 32'd0) ||
			(cipher_item.out_valid_bytes == 3'd1 && cipher_item.cipher_word[31:8] == 24'd0) ||
			(cipher_item.out_valid_bytes == 3'd2 && cipher_item.cipher_word[31:16] == 16'd0) ||
			(cipher_item.out_valid_bytes == 3'd3 && cipher_item.cipher_word[31:24] == 8'd0) ||
			(cipher_item.out_valid_bytes > 3'd3))
		else $error("cipher byte beyond valid count not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cipher_valid && cipher_stall) |=> (cipher_valid && $stable(cipher_item)))
		else $error("stalled result dropped or changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(plain_valid && plain_stall) |=> (plain_valid && $stable(plain_item)))
		else $error("stalled input item dropped or changed");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (.*);

`default_nettype wire
